### sv/rsrg_pkg.sv
// Package for the RGBW sine rainbow generator: payload structs, register
// indexes, command and status types. No dependencies.
package rsrg_pkg;

  typedef struct packed {
    logic        func;
    logic [31:0] tick_time;
    logic [15:0] load_red;
    logic [15:0] load_green;
    logic [15:0] load_blue;
    logic [15:0] load_white;
  } in_item_t;

  typedef struct packed {
    logic [15:0] red_level;
    logic [15:0] green_level;
    logic [15:0] blue_level;
    logic [15:0] white_level;
  } out_item_t;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_RED    = 3'd1;
  localparam logic [2:0] REG_GREEN  = 3'd2;
  localparam logic [2:0] REG_BLUE   = 3'd3;
  localparam logic [2:0] REG_PERIOD = 3'd4;
  localparam logic [2:0] REG_GAIN   = 3'd5;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  typedef struct packed {
    logic       load;
    logic       chan_start;
    logic [1:0] chan;
    logic       div_step;
    logic       mul_step;
    logic       store;
  } rsrg_cmd_t;

  typedef struct packed {
    logic div_done;
  } rsrg_sts_t;

endpackage

### sv/rgbw_sine_rainbow_generator_top.sv
// RGBW sine rainbow generator, top level.
// Every input transaction yields one result transaction holding the colour.
// func=1 loads R,G,B,W; func=0 is a tick: in rainbow mode R,G,B become
// |sin(pi*(t+offset)/(2*period))| scaled by the Q8.8 gain, saturated.
// In manual mode a tick returns the stored colour unchanged.
// Configuration writes set mode (clears the colour), offsets, period, gain.
// A load or manual tick goes straight to the output register; a rainbow tick
// first runs each of R, G and B in turn through the bit-serial divider that
// reduces t+offset modulo 2*period, one quotient bit per cycle per channel.
// One item is in work at a time; the next item is taken in the cycle after
// the previous result has moved into the output register.
// Reset clears the colour to black, mode to manual, period to 1000 and the
// gain to 1.0. A stalled receiver holds out_valid and the payload steady,
// and a finished item then waits, keeping in_ready low.
module rgbw_sine_rainbow_generator_top #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int LEVEL_BITS      = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rsrg_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rsrg_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import rsrg_pkg::*;

  rsrg_cmd_t  cmd;
  rsrg_sts_t  sts;
  out_item_t  colour;
  logic       mode, busy, done, in_fire, out_free;
  in_item_t   item_r;
  logic       out_valid_r;
  out_item_t  out_data_r;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (in_fire) item_r <= in_data;
  end

  rsrg_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_func(in_data.func),
    .mode(mode), .out_free(out_free), .sts(sts), .cmd(cmd),
    .busy(busy), .done(done)
  );

  rsrg_datapath #(.SINE_TABLE_BITS(SINE_TABLE_BITS), .LEVEL_BITS(LEVEL_BITS))
    u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_valid), .cfg_idx(cfg_index),
    .cfg_val(cfg_data), .item(cmd.load ? in_data : item_r), .cmd(cmd),
    .sts(sts), .mode(mode), .colour(colour)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (done) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) out_data_r <= colour;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule

### sv/rsrg_sine_rom.sv
// Sine table for the rainbow generator: |sin| in Q0.LEVEL_BITS computed by
// a Taylor series at elaboration. Depends on nothing.
module rsrg_sine_rom #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int LEVEL_BITS      = 16
) (
  input  logic                       clk,
  input  logic [SINE_TABLE_BITS-1:0] addr,
  output logic [LEVEL_BITS-1:0]      data_r
);
  localparam int DEPTH = 1 << SINE_TABLE_BITS;

  function automatic logic [LEVEL_BITS-1:0] entry(input int k);
    logic [63:0] x, x2, term, full, j, s;
    longint      acc;
    int          n;
    full = 64'(DEPTH);
    j = 64'(k);
    if (j > full / 2) j = full - j;
    x = (64'd3373259426 * j) >> SINE_TABLE_BITS;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (n = 1; n <= 5; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > 64'sd1073741824) acc = 64'sd1073741824;
    s = (64'(acc) + (64'd1 << (29 - LEVEL_BITS))) >> (30 - LEVEL_BITS);
    if (s > (64'd1 << LEVEL_BITS) - 1) s = (64'd1 << LEVEL_BITS) - 1;
    return s[LEVEL_BITS-1:0];
  endfunction

  logic [LEVEL_BITS-1:0] rom [DEPTH];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) rom[i] = entry(i);
  end

  always_ff @(posedge clk) begin
    data_r <= rom[addr];
  end
endmodule

### sv/rsrg_datapath.sv
// Datapath of the rainbow generator: colour store, bit-serial restoring
// divider, sine table lookup and gain multiply. Uses rsrg_pkg, rsrg_sine_rom.
module rsrg_datapath #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int LEVEL_BITS      = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [31:0]         cfg_val,
  input  rsrg_pkg::in_item_t  item,
  input  rsrg_pkg::rsrg_cmd_t cmd,
  output rsrg_pkg::rsrg_sts_t sts,
  output logic                mode,
  output rsrg_pkg::out_item_t colour
);
  import rsrg_pkg::*;

  localparam int NB = 33 + SINE_TABLE_BITS;
  localparam int CW = $clog2(NB + 1);

  logic        mode_r;
  logic [31:0] off_r [3];
  logic [15:0] period_r, gain_r;
  logic [15:0] col_r [4];
  logic [NB-1:0] num_r;
  logic [17:0]   rem_r;
  logic [CW-1:0] cnt_r;
  logic [SINE_TABLE_BITS-1:0] k;
  logic [LEVEL_BITS-1:0] sine;
  logic [31:0] prod_r;
  logic [16:0] span;
  logic [17:0] trial;
  logic [31:0] off_sel;
  logic [32:0] sum;
  logic [15:0] lvl;

  assign span = (period_r == 16'd0) ? 17'd2 : {period_r, 1'b0};
  assign trial = {rem_r[16:0], num_r[NB-1]};
  assign off_sel = off_r[cmd.chan];
  assign sum = {1'b0, item.tick_time} + {1'b0, off_sel};
  assign k = num_r[SINE_TABLE_BITS-1:0];
  assign sts.div_done = (cnt_r == CW'(NB));

  rsrg_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS), .LEVEL_BITS(LEVEL_BITS))
    u_rom (.clk(clk), .addr(k), .data_r(sine));

  assign lvl = (prod_r[31:24] != 8'd0) ? 16'hFFFF : prod_r[23:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      off_r[0] <= '0;
      off_r[1] <= '0;
      off_r[2] <= '0;
      period_r <= 16'd1000;
      gain_r   <= 16'd256;
      for (int i = 0; i < 4; i++) col_r[i] <= '0;
      cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_MODE: begin
            mode_r <= cfg_val[0];
            for (int i = 0; i < 4; i++) col_r[i] <= '0;
          end
          REG_RED:    off_r[0] <= cfg_val;
          REG_GREEN:  off_r[1] <= cfg_val;
          REG_BLUE:   off_r[2] <= cfg_val;
          REG_PERIOD: period_r <= cfg_val[15:0];
          REG_GAIN:   gain_r <= cfg_val[15:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        col_r[0] <= item.load_red;
        col_r[1] <= item.load_green;
        col_r[2] <= item.load_blue;
        col_r[3] <= item.load_white;
      end
      if (cmd.chan_start) begin
        num_r <= {sum, {SINE_TABLE_BITS{1'b0}}};
        rem_r <= '0;
        cnt_r <= '0;
      end else if (cmd.div_step && !sts.div_done) begin
        if (trial >= {1'b0, span}) begin
          rem_r <= trial - {1'b0, span};
          num_r <= {num_r[NB-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          num_r <= {num_r[NB-2:0], 1'b0};
        end
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.mul_step) begin
        prod_r <= (32'(sine) << (16 - LEVEL_BITS)) * 32'(gain_r);
      end
      if (cmd.store) col_r[cmd.chan] <= lvl;
    end
  end

  assign mode = mode_r;
  assign colour.red_level   = col_r[0];
  assign colour.green_level = col_r[1];
  assign colour.blue_level  = col_r[2];
  assign colour.white_level = col_r[3];
endmodule

### sv/rsrg_ctrl.sv
// Controller of the rainbow generator: sequences the three channels through
// divide, lookup, multiply and store. Uses rsrg_pkg.
module rsrg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                in_func,
  input  logic                mode,
  input  logic                out_free,
  input  rsrg_pkg::rsrg_sts_t sts,
  output rsrg_pkg::rsrg_cmd_t cmd,
  output logic                busy,
  output logic                done
);
  import rsrg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_DIV, S_ROM, S_MUL, S_STORE, S_DONE
  } state_t;

  state_t     state_r;
  logic [1:0] chan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chan_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_fire) begin
          chan_r <= '0;
          state_r <= (in_func == FUNC_TICK && mode) ? S_START : S_DONE;
        end
        S_START: state_r <= S_DIV;
        S_DIV:   if (sts.div_done) state_r <= S_ROM;
        S_ROM:   state_r <= S_MUL;
        S_MUL:   state_r <= S_STORE;
        S_STORE: begin
          if (chan_r == 2'd2) state_r <= S_DONE;
          else begin
            chan_r <= chan_r + 2'd1;
            state_r <= S_START;
          end
        end
        S_DONE:  if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.load       = in_fire && in_func == FUNC_LOAD;
    cmd.chan_start = state_r == S_START;
    cmd.chan       = chan_r;
    cmd.div_step   = state_r == S_DIV;
    cmd.mul_step   = state_r == S_MUL;
    cmd.store      = state_r == S_STORE;
  end

  assign busy = state_r != S_IDLE;
  assign done = state_r == S_DONE && out_free;

  a_chan: assert property (@(posedge clk) disable iff (!rst_n) chan_r != 2'd3)
    else $error("channel index out of range");
  a_store: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> $past(cmd.mul_step)) else $error("store without multiply");
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !busy) else $error("accept while busy");
endmodule
